[rtl/core/masked_row_gaussian_blur_macros.svh]
// Assertion macros used by the checker file of the row blur block.
`ifndef MASKED_ROW_GAUSSIAN_BLUR_MACROS_SVH
`define MASKED_ROW_GAUSSIAN_BLUR_MACROS_SVH

// Same-cycle implication, sampled on clk_i and idle during reset.
`define MRGB_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i and idle during reset.
`define MRGB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/mrgb_pkg.sv]
// Package of the row blur block: widths, register codes, types and the tap weight lookup.
`timescale 1ns / 1ps
package mrgb_pkg;

  localparam int unsigned MAX_RADIUS_DEF = 3;
  localparam int unsigned POS_W      = 4;
  localparam int unsigned CH_W       = 8;
  localparam int unsigned PIX_W      = 3 * CH_W;
  localparam int unsigned W_W        = 16;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned RAD_W      = 2;
  localparam int unsigned DIST_W     = 8;

  localparam logic [RAD_W-1:0] RADIUS_RST = 2'd3;
  localparam logic [W_W-1:0]   W0_RST     = 16'd26149;
  localparam logic [W_W-1:0]   W1_RST     = 16'd15860;
  localparam logic [W_W-1:0]   W2_RST     = 16'd3539;
  localparam logic [W_W-1:0]   W3_RST     = 16'd288;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RADIUS   = 3'd0,
    CFG_W_CENTER = 3'd1,
    CFG_W_ONE    = 3'd2,
    CFG_W_TWO    = 3'd3,
    CFG_W_THREE  = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [W_W-1:0] w0;
    logic [W_W-1:0] w1;
    logic [W_W-1:0] w2;
    logic [W_W-1:0] w3;
  } weights_t;

  // Describes one output word: the center index, the radius and the row end mark.
  typedef struct packed {
    logic [POS_W-1:0] c;
    logic [POS_W-1:0] r;
    logic             last;
  } job_meta_t;

  // Weight of a tap at the given distance; taps beyond three have none.
  function automatic logic [W_W-1:0] tap_weight(weights_t w, logic [DIST_W-1:0] d);
    logic [W_W-1:0] res;
    unique case (d)
      8'd0:    res = w.w0;
      8'd1:    res = w.w1;
      8'd2:    res = w.w2;
      8'd3:    res = w.w3;
      default: res = '0;
    endcase
    return res;
  endfunction

endpackage

[rtl/core/mrgb_if.sv]
// Stream interfaces of the row blur block: the pixel input and the result output.
`timescale 1ns / 1ps
interface mrgb_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] blue_in;
  logic [7:0] green_in;
  logic [7:0] red_in;
  logic       mask_set;
  logic       row_end;

  modport source (output valid, blue_in, green_in, red_in, mask_set, row_end, input ready);
  modport sink   (input valid, blue_in, green_in, red_in, mask_set, row_end, output ready);
endinterface

interface mrgb_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] blue_out;
  logic [7:0] green_out;
  logic [7:0] red_out;
  logic       row_end_out;
  logic       no_weight;

  modport source (output valid, blue_out, green_out, red_out, row_end_out, no_weight,
                  input ready);
  modport sink   (input valid, blue_out, green_out, red_out, row_end_out, no_weight,
                  output ready);
endinterface

[rtl/core/masked_row_gaussian_blur.sv]
// Top level of the masked row blur: configuration registers, front, job queue and back.
//
// Pixels enter on pix_in as valid/ready words with a mask bit and a row end mark;
// filtered words leave on res_out. Configuration is a plain write port: cfg_we_i,
// cfg_idx_i (0 radius, 1..4 center and offset weights) and cfg_data_i, taken at any
// edge with the enable high; write it only while no word is in flight.
// Output for a pixel appears once the pixel radius places to its right has arrived;
// the row end pixel releases all pixels still pending, the last one marked row_end_out.
// Each result word passes through the back part in order: one load, one
// multiply-accumulate per window entry, one setup and eight restoring divide
// steps, then the result register. A word with no tap weight skips the divide.
// The back part takes a new job only once the previous result word has been
// taken. The front takes one pixel per cycle while the two-entry job queue has
// room, and stalls at a row end while it issues the flush jobs.
// Reset clears the window, row position, queue and result valid flag and loads the
// default radius and weights. When the receiver stalls, the result word holds, the
// back part waits, the queue fills and then pix_in ready drops.
`timescale 1ns / 1ps
module masked_row_gaussian_blur #(
  parameter int unsigned MAX_RADIUS = mrgb_pkg::MAX_RADIUS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  mrgb_pix_if.sink                        pix_in,
  mrgb_res_if.source                      res_out,
  input  logic                            cfg_we_i,
  input  logic [mrgb_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [mrgb_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import mrgb_pkg::*;

  localparam int unsigned WIN   = 2 * MAX_RADIUS + 1;
  localparam int unsigned JOB_W = WIN * PIX_W + WIN + $bits(job_meta_t);

  logic [RAD_W-1:0]          radius_q;
  weights_t                  weights_q;

  logic                      f_valid, f_ready, b_valid, b_ready;
  logic [WIN-1:0][PIX_W-1:0] f_pix, b_pix;
  logic [WIN-1:0]            f_msk, b_msk;
  job_meta_t                 f_meta, b_meta;
  logic [JOB_W-1:0]          q_wr, q_rd;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q     <= RADIUS_RST;
      weights_q.w0 <= W0_RST;
      weights_q.w1 <= W1_RST;
      weights_q.w2 <= W2_RST;
      weights_q.w3 <= W3_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_RADIUS:   radius_q     <= cfg_data_i[RAD_W-1:0];
        CFG_W_CENTER: weights_q.w0 <= cfg_data_i;
        CFG_W_ONE:    weights_q.w1 <= cfg_data_i;
        CFG_W_TWO:    weights_q.w2 <= cfg_data_i;
        CFG_W_THREE:  weights_q.w3 <= cfg_data_i;
        default: ;
      endcase
    end
  end

  mrgb_front #(.MAX_RADIUS(MAX_RADIUS), .WIN(WIN)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (pix_in.valid),
    .in_ready_o  (pix_in.ready),
    .in_pix_i    ({pix_in.red_in, pix_in.green_in, pix_in.blue_in}),
    .in_mask_i   (pix_in.mask_set),
    .in_end_i    (pix_in.row_end),
    .radius_i    (radius_q),
    .job_valid_o (f_valid),
    .job_ready_i (f_ready),
    .job_pix_o   (f_pix),
    .job_msk_o   (f_msk),
    .job_meta_o  (f_meta)
  );

  // Jobs travel through the queue as one flat word.
  assign q_wr = {f_pix, f_msk, f_meta};
  assign {b_pix, b_msk, b_meta} = q_rd;

  mrgb_queue #(.DATA_W(JOB_W), .DEPTH(2)) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (f_valid),
    .wr_ready_o (f_ready),
    .wr_data_i  (q_wr),
    .rd_valid_o (b_valid),
    .rd_ready_i (b_ready),
    .rd_data_o  (q_rd)
  );

  mrgb_back #(.MAX_RADIUS(MAX_RADIUS), .WIN(WIN)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (b_valid),
    .job_ready_o (b_ready),
    .job_pix_i   (b_pix),
    .job_msk_i   (b_msk),
    .job_meta_i  (b_meta),
    .weights_i   (weights_q),
    .res         (res_out)
  );

endmodule

[rtl/core/mrgb_front.sv]
// Front part: takes pixels, keeps the row window and issues one job per output word.
`timescale 1ns / 1ps
module mrgb_front #(
  parameter int unsigned MAX_RADIUS = mrgb_pkg::MAX_RADIUS_DEF,
  parameter int unsigned WIN        = 2 * MAX_RADIUS + 1
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [mrgb_pkg::PIX_W-1:0]   in_pix_i,
  input  logic                         in_mask_i,
  input  logic                         in_end_i,
  input  logic [mrgb_pkg::RAD_W-1:0]   radius_i,
  output logic                         job_valid_o,
  input  logic                         job_ready_i,
  output logic [WIN-1:0][mrgb_pkg::PIX_W-1:0] job_pix_o,
  output logic [WIN-1:0]               job_msk_o,
  output mrgb_pkg::job_meta_t          job_meta_o
);
  import mrgb_pkg::*;

  typedef enum logic {F_IDLE, F_FLUSH} fstate_e;

  fstate_e                    state_q;
  logic [WIN-1:0][PIX_W-1:0]  win_pix_q, sh_pix;
  logic [WIN-1:0]             win_msk_q, sh_msk;
  logic [POS_W-1:0]           pos_q, cnt_q;
  logic [POS_W-1:0]           r_eff, c_first;
  logic                       accept;

  // Radius in use, limited to what the window holds.
  assign r_eff = ({{(POS_W-RAD_W){1'b0}}, radius_i} > POS_W'(MAX_RADIUS)) ?
                 POS_W'(MAX_RADIUS) : {{(POS_W-RAD_W){1'b0}}, radius_i};
  assign c_first = (pos_q < r_eff) ? pos_q : r_eff;

  // Window after the incoming pixel is shifted in.
  always_comb begin
    sh_pix[0] = in_pix_i;
    sh_msk[0] = in_mask_i;
    for (int i = 1; i < WIN; i++) begin
      sh_pix[i] = win_pix_q[i-1];
      sh_msk[i] = win_msk_q[i-1];
    end
  end

  assign in_ready_o = (state_q == F_IDLE) && job_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  // Job issue: from the shifted window on a new pixel, from the held window while flushing.
  always_comb begin
    job_pix_o       = sh_pix;
    job_msk_o       = sh_msk;
    job_meta_o.r    = r_eff;
    job_meta_o.c    = r_eff;
    job_meta_o.last = 1'b0;
    job_valid_o     = 1'b0;
    unique case (state_q)
      F_IDLE: begin
        if (accept) begin
          if (in_end_i) begin
            job_valid_o     = 1'b1;
            job_meta_o.c    = c_first;
            job_meta_o.last = (c_first == '0);
          end else begin
            job_valid_o = (pos_q >= r_eff);
          end
        end
      end
      F_FLUSH: begin
        job_pix_o       = win_pix_q;
        job_msk_o       = win_msk_q;
        job_valid_o     = 1'b1;
        job_meta_o.c    = cnt_q;
        job_meta_o.last = (cnt_q == '0);
      end
      default: ;
    endcase
  end

  // Window, row position and flush sequencing.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= F_IDLE;
      win_pix_q <= '0;
      win_msk_q <= '0;
      pos_q     <= '0;
      cnt_q     <= '0;
    end else begin
      unique case (state_q)
        F_IDLE: begin
          if (accept) begin
            if (!in_end_i) begin
              win_pix_q <= sh_pix;
              win_msk_q <= sh_msk;
              pos_q     <= (pos_q < POS_W'(MAX_RADIUS)) ? pos_q + 1'b1 : POS_W'(MAX_RADIUS);
            end else if (c_first == '0) begin
              win_pix_q <= '0;
              win_msk_q <= '0;
              pos_q     <= '0;
            end else begin
              win_pix_q <= sh_pix;
              win_msk_q <= sh_msk;
              cnt_q     <= c_first - 1'b1;
              state_q   <= F_FLUSH;
            end
          end
        end
        F_FLUSH: begin
          if (job_ready_i) begin
            if (cnt_q == '0) begin
              win_pix_q <= '0;
              win_msk_q <= '0;
              pos_q     <= '0;
              state_q   <= F_IDLE;
            end else begin
              cnt_q <= cnt_q - 1'b1;
            end
          end
        end
        default: state_q <= F_IDLE;
      endcase
    end
  end

endmodule

[rtl/core/mrgb_queue.sv]
// Short job queue between the front and the back part.
`timescale 1ns / 1ps
module mrgb_queue #(
  parameter int unsigned DATA_W = 8,
  parameter int unsigned DEPTH  = 2
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              wr_valid_i,
  output logic              wr_ready_o,
  input  logic [DATA_W-1:0] wr_data_i,
  output logic              rd_valid_o,
  input  logic              rd_ready_i,
  output logic [DATA_W-1:0] rd_data_o
);
  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0]  cnt_q;
  logic              push, pop;

  assign wr_ready_o = (cnt_q != CNT_W'(DEPTH));
  assign rd_valid_o = (cnt_q != '0);
  assign rd_data_o  = mem_q[rd_ptr_q];
  assign push       = wr_valid_i && wr_ready_o;
  assign pop        = rd_valid_o && rd_ready_i;

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

[rtl/core/mrgb_back.sv]
// Back part: weighted sums over the window, an 8-step divider and the result register.
`timescale 1ns / 1ps
module mrgb_back #(
  parameter int unsigned MAX_RADIUS = mrgb_pkg::MAX_RADIUS_DEF,
  parameter int unsigned WIN        = 2 * MAX_RADIUS + 1
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                job_valid_i,
  output logic                                job_ready_o,
  input  logic [WIN-1:0][mrgb_pkg::PIX_W-1:0] job_pix_i,
  input  logic [WIN-1:0]                      job_msk_i,
  input  mrgb_pkg::job_meta_t                 job_meta_i,
  input  mrgb_pkg::weights_t                  weights_i,
  mrgb_res_if.source                          res
);
  import mrgb_pkg::*;

  localparam int unsigned IDX_W = $clog2(WIN);
  localparam int unsigned DW    = (IDX_W > POS_W) ? IDX_W : POS_W;
  localparam int unsigned SUM_W = $clog2(WIN + 1);
  localparam int unsigned WS_W  = W_W + SUM_W;
  localparam int unsigned ACC_W = WS_W + CH_W;

  typedef enum logic [2:0] {B_IDLE, B_MAC, B_PREP, B_DIV, B_OUT} bstate_e;

  bstate_e                   state_q;
  logic [WIN-1:0][PIX_W-1:0] pix_q;
  logic [WIN-1:0]            msk_q;
  job_meta_t                 meta_q;
  logic [IDX_W-1:0]          j_q;
  logic [2:0]                k_q;
  logic [ACC_W-1:0]          acc_q [3];
  logic [WS_W-1:0]           wsum_q;
  logic [WS_W-1:0]           rem_q [3];
  logic [CH_W-1:0]           quo_q [3];
  logic                      out_valid_q;
  logic [CH_W-1:0]           out_ch_q [3];
  logic                      out_end_q, out_now_q;

  logic [DW-1:0]             jx, cx, tap_dist;
  logic                      tap_ok;
  logic [W_W-1:0]            w_tap;
  logic [2:0]                bit_sel;
  logic [WS_W:0]             trial [3];
  logic                      qbit [3];
  logic [PIX_W-1:0]          ctr_pix;

  // Tap at window index j: distance to the center, range and mask test.
  assign jx       = DW'(j_q);
  assign cx       = DW'(meta_q.c);
  assign tap_dist = (jx >= cx) ? (jx - cx) : (cx - jx);
  assign tap_ok   = (tap_dist <= DW'(meta_q.r)) && msk_q[j_q];
  assign w_tap    = tap_ok ? tap_weight(weights_i, DIST_W'(tap_dist)) : '0;

  // One restoring division step per channel, bringing in the next dividend bit.
  assign bit_sel = 3'(CH_W - 1) - k_q;
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      trial[ch] = {rem_q[ch], acc_q[ch][bit_sel]};
      qbit[ch]  = (trial[ch] >= {1'b0, wsum_q});
    end
  end

  assign ctr_pix     = pix_q[meta_q.c[IDX_W-1:0]];
  assign job_ready_o = (state_q == B_IDLE);

  assign res.valid       = out_valid_q;
  assign res.blue_out    = out_ch_q[0];
  assign res.green_out   = out_ch_q[1];
  assign res.red_out     = out_ch_q[2];
  assign res.row_end_out = out_end_q;
  assign res.no_weight   = out_now_q;

  // Sequencer: load a job, accumulate over the window, divide, hold the result word.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      unique case (state_q)
        B_IDLE: begin
          if (job_valid_i) begin
            pix_q   <= job_pix_i;
            msk_q   <= job_msk_i;
            meta_q  <= job_meta_i;
            j_q     <= '0;
            wsum_q  <= '0;
            for (int ch = 0; ch < 3; ch++) acc_q[ch] <= '0;
            state_q <= B_MAC;
          end
        end
        B_MAC: begin
          wsum_q <= wsum_q + WS_W'(w_tap);
          for (int ch = 0; ch < 3; ch++) begin
            acc_q[ch] <= acc_q[ch] +
                         ACC_W'(w_tap) * ACC_W'(pix_q[j_q][ch*CH_W +: CH_W]);
          end
          if (j_q == IDX_W'(WIN - 1)) begin
            state_q <= B_PREP;
          end else begin
            j_q <= j_q + 1'b1;
          end
        end
        B_PREP: begin
          k_q <= '0;
          for (int ch = 0; ch < 3; ch++) rem_q[ch] <= acc_q[ch][ACC_W-1:CH_W];
          if (wsum_q == '0) begin
            for (int ch = 0; ch < 3; ch++) out_ch_q[ch] <= ctr_pix[ch*CH_W +: CH_W];
            out_end_q   <= meta_q.last;
            out_now_q   <= 1'b1;
            out_valid_q <= 1'b1;
            state_q     <= B_OUT;
          end else begin
            state_q <= B_DIV;
          end
        end
        B_DIV: begin
          for (int ch = 0; ch < 3; ch++) begin
            rem_q[ch] <= qbit[ch] ? WS_W'(trial[ch] - {1'b0, wsum_q}) : WS_W'(trial[ch]);
            quo_q[ch] <= {quo_q[ch][CH_W-2:0], qbit[ch]};
          end
          if (k_q == 3'(CH_W - 1)) begin
            for (int ch = 0; ch < 3; ch++) out_ch_q[ch] <= {quo_q[ch][CH_W-2:0], qbit[ch]};
            out_end_q   <= meta_q.last;
            out_now_q   <= 1'b0;
            out_valid_q <= 1'b1;
            state_q     <= B_OUT;
          end else begin
            k_q <= k_q + 1'b1;
          end
        end
        B_OUT: begin
          if (res.ready) begin
            out_valid_q <= 1'b0;
            state_q     <= B_IDLE;
          end
        end
        default: state_q <= B_IDLE;
      endcase
    end
  end

endmodule

[rtl/core/mrgb_checker.sv]
// Port-level checker of the row blur block and its bind to the top level.
`timescale 1ns / 1ps
`include "masked_row_gaussian_blur_macros.svh"
module mrgb_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       in_end_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] out_blue_i,
  input logic [7:0] out_green_i,
  input logic [7:0] out_red_i,
  input logic       out_end_i,
  input logic       out_now_i
);
  logic [3:0] ends_owed_q;
  logic       in_end_acc, out_end_acc;

  assign in_end_acc  = in_valid_i && in_ready_i && in_end_i;
  assign out_end_acc = out_valid_i && out_ready_i && out_end_i;

  // Row ends taken in but not yet delivered as a marked result word.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ends_owed_q <= '0;
    end else if (in_end_acc && !out_end_acc) begin
      ends_owed_q <= ends_owed_q + 1'b1;
    end else if (out_end_acc && !in_end_acc) begin
      ends_owed_q <= ends_owed_q - 1'b1;
    end
  end

  `MRGB_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i, "result word dropped")
  `MRGB_ASSERT_NEXT(a_out_stable, out_valid_i && !out_ready_i, $stable({out_blue_i, out_green_i, out_red_i, out_end_i, out_now_i}), "stalled result changed")
  `MRGB_ASSERT_NOW(a_reset_quiet, $rose(rst_ni), !out_valid_i, "result word right after reset")
  `MRGB_ASSERT_NOW(a_end_owed, out_end_acc, ends_owed_q != 4'd0, "row end delivered with none taken in")

endmodule

bind masked_row_gaussian_blur mrgb_checker u_mrgb_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (pix_in.valid),
  .in_ready_i  (pix_in.ready),
  .in_end_i    (pix_in.row_end),
  .out_valid_i (res_out.valid),
  .out_ready_i (res_out.ready),
  .out_blue_i  (res_out.blue_out),
  .out_green_i (res_out.green_out),
  .out_red_i   (res_out.red_out),
  .out_end_i   (res_out.row_end_out),
  .out_now_i   (res_out.no_weight)
);
